// File: src/prt_pkg.sv
// Package for the pulse rise time block: field widths, register codes,
// reset values and the job descriptor passed from loader to evaluator.
// No dependencies.
package prt_pkg;

  localparam int TIME_W     = 32;
  localparam int AMP_W      = 16;
  localparam int PEAK_W     = 15;
  localparam int RISE_W     = 33;
  localparam int IDX_W      = 11;
  localparam int SW_W       = 12;
  localparam int NF_W       = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = 21;
  localparam int JOBQ_DEPTH = 2;

  // Configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR   = CFG_IDX_W'(1);

  localparam logic [SW_W-1:0] SEARCH_WINDOW_RST = SW_W'(1200);
  localparam logic [NF_W-1:0] NOISE_FLOOR_RST   = NF_W'(66);

  // Fixed-point threshold factors: 10*y against peak and 9*peak
  localparam logic signed [CMP_W-1:0] SCALE_Y  = CMP_W'(10);
  localparam logic signed [CMP_W-1:0] SCALE_HI = CMP_W'(9);

  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic              noise;
    logic              ovf;
  } prt_job_t;

endpackage

// File: src/prt_if.sv
// Stream and configuration interfaces of the pulse rise time block.
// Depends on prt_pkg.
interface prt_sample_if;
  import prt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TIME_W-1:0] sample_time;
  logic signed [AMP_W-1:0]  amplitude;
  logic                     last_sample;
  modport source(output valid, sample_time, amplitude, last_sample, input ready);
  modport sink(input valid, sample_time, amplitude, last_sample, output ready);
endinterface

interface prt_result_if;
  import prt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RISE_W-1:0] rise_time;
  logic signed [TIME_W-1:0] start_time;
  logic signed [TIME_W-1:0] end_time;
  logic [IDX_W-1:0]         start_index;
  logic [IDX_W-1:0]         end_index;
  logic [PEAK_W-1:0]        peak_amplitude;
  logic [IDX_W-1:0]         peak_index;
  logic                     below_noise;
  logic                     overflowed;
  modport source(output valid, rise_time, start_time, end_time, start_index, end_index,
                 peak_amplitude, peak_index, below_noise, overflowed, input ready);
  modport sink(input valid, rise_time, start_time, end_time, start_index, end_index,
               peak_amplitude, peak_index, below_noise, overflowed, output ready);
endinterface

interface prt_cfg_if;
  import prt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: src/prt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/prt_front.sv
// Loader: takes sample beats, writes the sample buffer, tracks the peak and
// holds the configuration registers; pushes one job per record.
// Depends on prt_pkg and prt_if.
module prt_front #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  prt_cfg_if.sink                    cfg,
  prt_sample_if.sink                 samples,
  input  logic                       hold,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [prt_pkg::TIME_W+prt_pkg::AMP_W-1:0] ram_wdata,
  output logic                       job_push,
  output prt_pkg::prt_job_t          job,
  output logic [AW-1:0]              job_pidx
);
  import prt_pkg::*;

  localparam int CW = AW + 1;
  localparam int CMPW = (CW > SW_W) ? CW : SW_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [SW_W-1:0]   search_window;
  logic [NF_W-1:0]   noise_floor;
  logic [CW-1:0]     count, count_next;
  logic [PEAK_W-1:0] peak, peak_next;
  logic [AW-1:0]     pidx, pidx_next;
  logic              ovf, ovf_next;
  logic              acc;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !hold;
  assign acc           = samples.valid && !hold;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      search_window <= SEARCH_WINDOW_RST;
      noise_floor   <= NOISE_FLOOR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SEARCH_WINDOW: search_window <= cfg.data[SW_W-1:0];
        REG_NOISE_FLOOR:   noise_floor   <= cfg.data[NF_W-1:0];
        default: ;
      endcase
    end
  end

  // Store the sample and update the running peak, or flag overflow when the buffer is full
  always_comb begin
    count_next = count;
    peak_next  = peak;
    pidx_next  = pidx;
    ovf_next   = ovf;
    ram_we     = 1'b0;
    if (acc) begin
      if (count < DEPTH_CNT) begin
        ram_we = 1'b1;
        if (CMPW'(count) < CMPW'(search_window) && !samples.amplitude[AMP_W-1] &&
            samples.amplitude[PEAK_W-1:0] > peak) begin
          peak_next = samples.amplitude[PEAK_W-1:0];
          pidx_next = count[AW-1:0];
        end
        count_next = count + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = {samples.sample_time, samples.amplitude};

  // Close the record on its last beat
  assign job_push  = acc && samples.last_sample;
  assign job.peak  = peak_next;
  assign job.noise = peak_next < noise_floor;
  assign job.ovf   = ovf_next;
  assign job_pidx  = pidx_next;

  always_ff @(posedge clk) begin
    if (rst || job_push) begin
      count <= '0;
      peak  <= '0;
      pidx  <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      peak  <= peak_next;
      pidx  <= pidx_next;
      ovf   <= ovf_next;
    end
  end

endmodule

// File: src/prt_job_fifo.sv
// Short job queue between loader and evaluator.
// Depends on prt_pkg.
module prt_job_fifo #(
  parameter int WIDTH = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] pop_data
);
  import prt_pkg::*;

  localparam int PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int NW = $clog2(JOBQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(JOBQ_DEPTH - 1);

  logic [WIDTH-1:0] slots [JOBQ_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_push, do_pop;

  assign full     = fill == NW'(JOBQ_DEPTH);
  assign nonempty = fill != '0;
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Hold entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// File: src/prt_back.sv
// Evaluator: takes a job, walks the sample buffer back from the peak for the
// 10 and 90 percent crossings and drives the result register.
// Depends on prt_pkg and prt_if.
module prt_back #(
  parameter int AW = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  prt_pkg::prt_job_t         job,
  input  logic [AW-1:0]             job_pidx,
  output logic                      job_pop,
  output logic                      busy,
  output logic                      ram_re,
  output logic [AW-1:0]             ram_raddr,
  input  logic [prt_pkg::TIME_W+prt_pkg::AMP_W-1:0] ram_rdata,
  prt_result_if.source              results
);
  import prt_pkg::*;

  typedef enum logic [2:0] {
    IDLE, PEAK_RD, PEAK_WAIT, WALK_LO, WALK_HI, DONE
  } state_t;

  state_t            state;
  logic [PEAK_W-1:0] peak;
  logic [AW-1:0]     pidx;
  logic              noise, ovf;
  logic [AW-1:0]     ptr, lb, pend_idx;
  logic              pend;
  logic [TIME_W-1:0] st, et;
  logic [AW-1:0]     sidx, eidx;

  logic signed [AMP_W-1:0]  rd_amp;
  logic [TIME_W-1:0]        rd_time;
  logic signed [CMP_W-1:0]  amp_x10, peak_lo, peak_hi;
  logic                     issue, hit_lo, hit_hi, out_free;

  assign rd_time = ram_rdata[TIME_W+AMP_W-1:AMP_W];
  assign rd_amp  = ram_rdata[AMP_W-1:0];

  // Fixed-point thresholds
  assign amp_x10 = CMP_W'(rd_amp) * SCALE_Y;
  assign peak_lo = $signed(CMP_W'(peak));
  assign peak_hi = $signed(CMP_W'(peak)) * SCALE_HI;
  assign hit_lo  = pend && (amp_x10 < peak_lo);
  assign hit_hi  = pend && (amp_x10 < peak_hi);

  assign issue    = ptr > lb;
  assign out_free = !results.valid || results.ready;
  assign busy     = state != IDLE && state != DONE;
  assign job_pop  = state == IDLE && job_valid;

  // Read port: peak entry first, then one entry per cycle during a walk
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr;
    unique case (state)
      PEAK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pidx;
      end
      WALK_LO, WALK_HI: ram_re = issue;
      default: ;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      pend          <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != DONE) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            peak  <= job.peak;
            noise <= job.noise;
            ovf   <= job.ovf;
            pidx  <= job_pidx;
            st    <= '0;
            et    <= '0;
            sidx  <= '0;
            eidx  <= '0;
            state <= job.noise ? DONE : PEAK_RD;
          end
        end
        PEAK_RD: state <= PEAK_WAIT;
        PEAK_WAIT: begin
          et    <= rd_time;
          eidx  <= pidx;
          ptr   <= pidx;
          lb    <= '0;
          pend  <= 1'b0;
          state <= WALK_LO;
        end
        WALK_LO: begin
          if (hit_lo) begin
            st    <= rd_time;
            sidx  <= pend_idx;
            lb    <= pend_idx;
            ptr   <= pidx;
            pend  <= 1'b0;
            state <= WALK_HI;
          end else if (issue) begin
            pend     <= 1'b1;
            pend_idx <= ptr;
            ptr      <= ptr - AW'(1);
          end else begin
            lb    <= '0;
            ptr   <= pidx;
            pend  <= 1'b0;
            state <= WALK_HI;
          end
        end
        WALK_HI: begin
          if (hit_hi) begin
            et    <= rd_time;
            eidx  <= pend_idx;
            pend  <= 1'b0;
            state <= DONE;
          end else if (issue) begin
            pend     <= 1'b1;
            pend_idx <= ptr;
            ptr      <= ptr - AW'(1);
          end else begin
            pend  <= 1'b0;
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            results.valid          <= 1'b1;
            results.rise_time      <= {et[TIME_W-1], et} - {st[TIME_W-1], st};
            results.start_time     <= st;
            results.end_time       <= et;
            results.start_index    <= IDX_W'(sidx);
            results.end_index      <= IDX_W'(eidx);
            results.peak_amplitude <= peak;
            results.peak_index     <= IDX_W'(pidx);
            results.below_noise    <= noise;
            results.overflowed     <= ovf;
            state                  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: src/pulse_rise_time_10_90.sv
// Pulse rise time (10 to 90 percent) of one waveform record.
//
// Channels: samples (sink) carries sample_time, amplitude and last_sample;
// results (source) carries one result beat per record; cfg (sink) writes
// register 0 (search_window) or 1 (noise_floor); other indexes are dropped.
// cfg.ready is always high.
// Loading: one sample beat per cycle while no record is under evaluation.
// Evaluation: after the last beat the evaluator reads the peak entry and
// walks back from the peak, one buffer entry per cycle, first to the 10
// percent crossing and then to the 90 percent crossing. The walks are paced
// by the single buffer read port; a record below the noise floor skips both
// walks and goes straight to its result. Samples of the next record are
// held off until both walks have finished.
// Stall: the result sits in an output register until taken; the loader may
// fill the next record meanwhile, and the evaluator waits to deliver.
// Reset clears the record state, the job queue and the result valid flag and
// restores register defaults; the buffer needs no clearing pass.
// Depends on prt_pkg, prt_if, prt_ram, prt_front, prt_job_fifo, prt_back.
module pulse_rise_time_10_90 #(
  parameter int DEPTH = 2048
) (
  input  logic          clk,
  input  logic          rst,
  prt_cfg_if.sink       cfg,
  prt_sample_if.sink    samples,
  prt_result_if.source  results
);
  import prt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int DW = TIME_W + AMP_W;
  localparam int JW = $bits(prt_job_t) + AW;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          job_push, job_pop, job_full, job_valid, back_busy, hold;
  prt_job_t      job_in, job_out;
  logic [AW-1:0] pidx_in, pidx_out;

  // Hold samples while a record waits or is being walked
  assign hold = job_valid || back_busy || job_full;

  prt_front #(.DEPTH(DEPTH), .AW(AW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .hold      (hold),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job_in),
    .job_pidx  (pidx_in)
  );

  prt_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prt_job_fifo #(.WIDTH(JW)) u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data ({pidx_in, job_in}),
    .full      (job_full),
    .pop       (job_pop),
    .nonempty  (job_valid),
    .pop_data  ({pidx_out, job_out})
  );

  prt_back #(.AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pidx  (pidx_out),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .results   (results)
  );

endmodule
